>>> rtl/rc4_pkg.sv
package rc4_pkg;

    localparam int BYTE_W     = 8;
    localparam int SBOX_DEPTH = 256;
    localparam int KEY_CNT_W  = 9;

    typedef logic [BYTE_W-1:0]    byte_t;
    typedef logic [KEY_CNT_W-1:0] key_cnt_t;

    // request kind carried on the input tuser bit
    typedef enum logic {
        REQ_KEY  = 1'b0,
        REQ_DATA = 1'b1
    } req_kind_t;

    // S-box port requests: one write port, two read ports
    typedef struct packed {
        logic  we;
        byte_t waddr;
        byte_t wdata;
        byte_t raddr_a;
        byte_t raddr_b;
    } sbox_req_t;

    // finished result handed to the output register
    typedef struct packed {
        logic  valid;
        byte_t data;
        logic  keyed;
    } res_t;

endpackage

>>> rtl/rc4_stream_cipher_core.sv
// RC4 stream cipher core.
// Input stream (s_*): tuser selects the request kind (0 = key byte, 1 = data
// byte), tdata carries the byte, tlast marks the final key byte. Key bytes
// are stored (beyond KEY_MAX_BYTES they are dropped) and give no result.
// A key byte with tlast set starts key scheduling: the identity S-box is
// loaded, then 256 swaps are made, each in read, j, write-i and write-j
// steps; s_tready is low throughout. The S-box has one write port, so each
// swap and keyed data byte writes twice, in separate steps after its reads.
// Output stream (m_*): one result per data byte; tdata is the data XOR the
// keystream byte, tuser is high when a key had been scheduled. Before the
// first key, data bytes pass unchanged with tuser low.
// Keyed data byte: steps through read-j, swap-i and swap-j after acceptance.
// Unkeyed data byte: a pass step. Key byte: none. New requests wait for idle.
// A result waits in the output register; the next request is accepted while
// it waits, and that request's own result holds at its last step until the
// register frees. Reset clears the key count, indices and keyed flag; the
// S-box and key store are not cleared.
module rc4_stream_cipher_core
    import rc4_pkg::*;
#(
    parameter int KEY_MAX_BYTES = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] byte_in
    input  logic       s_tuser,   // [0] mode
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] byte_out
    output logic       m_tuser    // [0] keyed
);

    localparam int KA_W = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;

    sbox_req_t       sbox_req;
    byte_t           sbox_rd_a;
    byte_t           sbox_rd_b;
    logic            key_we;
    logic [KA_W-1:0] key_waddr;
    byte_t           key_wdata;
    logic [KA_W-1:0] key_raddr;
    byte_t           key_rd;
    res_t            res;
    logic            out_free;

    logic            out_valid_reg, out_valid_next;
    byte_t           out_data_reg, out_data_next;
    logic            out_keyed_reg, out_keyed_next;

    rc4_sbox_ram u_sbox
    (
        .clk  (clk),
        .req  (sbox_req),
        .rd_a (sbox_rd_a),
        .rd_b (sbox_rd_b)
    );

    rc4_key_ram #(
        .KEY_MAX_BYTES (KEY_MAX_BYTES),
        .KA_W          (KA_W)
    ) u_key
    (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (key_raddr),
        .rdata (key_rd)
    );

    rc4_engine #(
        .KEY_MAX_BYTES (KEY_MAX_BYTES),
        .KA_W          (KA_W)
    ) u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .out_free  (out_free),
        .res       (res),
        .sbox_req  (sbox_req),
        .sbox_rd_a (sbox_rd_a),
        .sbox_rd_b (sbox_rd_b),
        .key_we    (key_we),
        .key_waddr (key_waddr),
        .key_wdata (key_wdata),
        .key_raddr (key_raddr),
        .key_rd    (key_rd)
    );

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_keyed_next = out_keyed_reg;
        if (res.valid)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res.data;
            out_keyed_next = res.keyed;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        out_keyed_reg <= out_keyed_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_keyed_reg;

endmodule

>>> rtl/rc4_sbox_ram.sv
module rc4_sbox_ram
    import rc4_pkg::*;
(
    input  logic      clk,
    input  sbox_req_t req,
    output byte_t     rd_a,
    output byte_t     rd_b
);

    byte_t sbox_mem [SBOX_DEPTH];
    byte_t rd_a_reg;
    byte_t rd_b_reg;

    // reads return the contents from before a write in the same cycle
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            sbox_mem[req.waddr] <= req.wdata;
        end
        rd_a_reg <= sbox_mem[req.raddr_a];
        rd_b_reg <= sbox_mem[req.raddr_b];
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

>>> rtl/rc4_key_ram.sv
module rc4_key_ram
    import rc4_pkg::*;
#(
    parameter int KEY_MAX_BYTES = 256,
    parameter int KA_W          = 8
)
(
    input  logic            clk,
    input  logic            we,
    input  logic [KA_W-1:0] waddr,
    input  byte_t           wdata,
    input  logic [KA_W-1:0] raddr,
    output byte_t           rdata
);

    byte_t key_mem [KEY_MAX_BYTES];
    byte_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_mem[waddr] <= wdata;
        end
        rdata_reg <= key_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/rc4_engine.sv
module rc4_engine
    import rc4_pkg::*;
#(
    parameter int KEY_MAX_BYTES = 256,
    parameter int KA_W          = 8
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  byte_t           s_tdata,
    input  logic            s_tuser,
    input  logic            s_tlast,
    input  logic            out_free,
    output res_t            res,
    output sbox_req_t       sbox_req,
    input  byte_t           sbox_rd_a,
    input  byte_t           sbox_rd_b,
    output logic            key_we,
    output logic [KA_W-1:0] key_waddr,
    output byte_t           key_wdata,
    output logic [KA_W-1:0] key_raddr,
    input  byte_t           key_rd
);

    localparam key_cnt_t KEY_LIMIT = KEY_CNT_W'(KEY_MAX_BYTES);
    localparam byte_t    LAST_IDX  = BYTE_W'(SBOX_DEPTH - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PASS,
        ST_DAT_RD_J,
        ST_DAT_SWAP_I,
        ST_DAT_SWAP_J,
        ST_INIT,
        ST_KSA_RD,
        ST_KSA_J,
        ST_KSA_WI,
        ST_KSA_WJ
    } state_t;

    state_t          state_reg, state_next;
    byte_t           i_reg, i_next;
    byte_t           j_reg, j_next;
    key_cnt_t        key_count_reg, key_count_next;
    logic [KA_W-1:0] kidx_reg, kidx_next;
    logic            is_keyed_reg, is_keyed_next;
    byte_t           byte_reg, byte_next;
    byte_t           sa_reg, sa_next;
    byte_t           sb_reg, sb_next;
    byte_t           t_reg, t_next;
    key_cnt_t        key_len;
    byte_t           ks;

    assign key_len = (key_count_reg == '0) ? KEY_CNT_W'(1) : key_count_reg;

    // forward the swap writes that the keystream read may have missed
    always_comb
    begin
        if (t_reg == j_reg)
        begin
            ks = sa_reg;
        end
        else if (t_reg == i_reg)
        begin
            ks = sb_reg;
        end
        else
        begin
            ks = sbox_rd_a;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        key_count_next = key_count_reg;
        kidx_next      = kidx_reg;
        is_keyed_next  = is_keyed_reg;
        byte_next      = byte_reg;
        sa_next        = sa_reg;
        sb_next        = sb_reg;
        t_next         = t_reg;
        sbox_req       = '0;
        key_we         = 1'b0;
        key_waddr      = key_count_reg[KA_W-1:0];
        key_wdata      = s_tdata;
        key_raddr      = kidx_reg;
        res            = '0;
        s_tready       = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == REQ_KEY)
                    begin
                        if (key_count_reg < KEY_LIMIT)
                        begin
                            key_we         = 1'b1;
                            key_count_next = key_count_reg + KEY_CNT_W'(1);
                        end
                        if (s_tlast)
                        begin
                            i_next     = '0;
                            state_next = ST_INIT;
                        end
                    end
                    else if (is_keyed_reg)
                    begin
                        i_next           = i_reg + 8'd1;
                        sbox_req.raddr_a = i_reg + 8'd1;
                        byte_next        = s_tdata;
                        state_next       = ST_DAT_RD_J;
                    end
                    else
                    begin
                        byte_next  = s_tdata;
                        state_next = ST_PASS;
                    end
                end
            end

            ST_PASS:
            begin
                if (out_free)
                begin
                    res        = '{valid: 1'b1, data: byte_reg, keyed: 1'b0};
                    state_next = ST_IDLE;
                end
            end

            ST_DAT_RD_J:
            begin
                j_next           = j_reg + sbox_rd_a;
                sbox_req.raddr_b = j_reg + sbox_rd_a;
                sa_next          = sbox_rd_a;
                state_next       = ST_DAT_SWAP_I;
            end

            ST_DAT_SWAP_I:
            begin
                sbox_req.we      = 1'b1;
                sbox_req.waddr   = i_reg;
                sbox_req.wdata   = sbox_rd_b;
                sbox_req.raddr_a = sa_reg + sbox_rd_b;
                sb_next          = sbox_rd_b;
                t_next           = sa_reg + sbox_rd_b;
                state_next       = ST_DAT_SWAP_J;
            end

            ST_DAT_SWAP_J:
            begin
                // hold here while the output register is full; the re-read stays valid
                sbox_req.we      = 1'b1;
                sbox_req.waddr   = j_reg;
                sbox_req.wdata   = sa_reg;
                sbox_req.raddr_a = t_reg;
                if (out_free)
                begin
                    res        = '{valid: 1'b1, data: byte_reg ^ ks, keyed: 1'b1};
                    state_next = ST_IDLE;
                end
            end

            ST_INIT:
            begin
                sbox_req.we    = 1'b1;
                sbox_req.waddr = i_reg;
                sbox_req.wdata = i_reg;
                i_next         = i_reg + 8'd1;
                if (i_reg == LAST_IDX)
                begin
                    j_next     = '0;
                    kidx_next  = '0;
                    state_next = ST_KSA_RD;
                end
            end

            ST_KSA_RD:
            begin
                sbox_req.raddr_a = i_reg;
                state_next       = ST_KSA_J;
            end

            ST_KSA_J:
            begin
                j_next           = j_reg + sbox_rd_a + key_rd;
                sbox_req.raddr_b = j_reg + sbox_rd_a + key_rd;
                sa_next          = sbox_rd_a;
                // advance the key index modulo the key length
                if (KEY_CNT_W'(kidx_reg) + KEY_CNT_W'(1) >= key_len)
                begin
                    kidx_next = '0;
                end
                else
                begin
                    kidx_next = kidx_reg + KA_W'(1);
                end
                state_next = ST_KSA_WI;
            end

            ST_KSA_WI:
            begin
                sbox_req.we    = 1'b1;
                sbox_req.waddr = i_reg;
                sbox_req.wdata = sbox_rd_b;
                state_next     = ST_KSA_WJ;
            end

            ST_KSA_WJ:
            begin
                sbox_req.we    = 1'b1;
                sbox_req.waddr = j_reg;
                sbox_req.wdata = sa_reg;
                i_next         = i_reg + 8'd1;
                if (i_reg == LAST_IDX)
                begin
                    j_next         = '0;
                    key_count_next = '0;
                    is_keyed_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_KSA_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            key_count_reg <= '0;
            kidx_reg      <= '0;
            is_keyed_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            key_count_reg <= key_count_next;
            kidx_reg      <= kidx_next;
            is_keyed_reg  <= is_keyed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        sa_reg   <= sa_next;
        sb_reg   <= sb_next;
        t_reg    <= t_next;
    end

    a_res_fits: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> out_free)
        else $error("result issued while output register is occupied");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_PASS || state_reg == ST_DAT_RD_J)
        |-> !sbox_req.we)
        else $error("S-box written outside a swap or schedule step");

    a_key_count: assert property (@(posedge clk) disable iff (!rst_n)
        key_count_reg <= KEY_LIMIT)
        else $error("key count beyond key store depth");

    a_sched_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_KSA_WJ && i_reg == LAST_IDX)
        |=> (is_keyed_reg && i_reg == '0 && j_reg == '0 && key_count_reg == '0))
        else $error("schedule end did not clear indices and set keyed");

    a_keyed_res: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.keyed) |-> is_keyed_reg)
        else $error("keyed result issued before a key was scheduled");

endmodule

>>> bench/rc4_checker.sv
`timescale 1ns / 100ps

module rc4_checker
    import rc4_pkg::*;
#(
    parameter int KEY_MAX_BYTES = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tuser,
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       m_tuser,
    output int         err_count,
    output int         pending
);

    typedef struct {
        byte_t data;
        logic  keyed;
    } cipher_out_t;

    byte_t       perm [SBOX_DEPTH];
    byte_t       key_mem [SBOX_DEPTH];
    int unsigned key_len;
    byte_t       gen_i;
    byte_t       gen_j;
    logic        keyed_now;
    cipher_out_t expected_out [$];
    int          err_total = 0;

    assign err_count = err_total;

    task automatic schedule_key();
        int unsigned len;
        byte_t       j;
        byte_t       t;
        len = (key_len == 0) ? 1 : key_len;
        for (int n = 0; n < SBOX_DEPTH; n++)
            perm[n] = byte_t'(n);
        j = '0;
        for (int n = 0; n < SBOX_DEPTH; n++)
        begin
            j = j + perm[n] + key_mem[n % len];
            t = perm[n];
            perm[n] = perm[j];
            perm[j] = t;
        end
        gen_i = '0;
        gen_j = '0;
        key_len = 0;
        keyed_now = 1'b1;
    endtask

    task automatic absorb_request(input req_kind_t kind, input byte_t b, input logic last);
        cipher_out_t r;
        byte_t       t;
        if (kind == REQ_KEY)
        begin
            if (key_len < KEY_MAX_BYTES && key_len < SBOX_DEPTH)
            begin
                key_mem[key_len] = b;
                key_len++;
            end
            if (last)
                schedule_key();
        end
        else
        begin
            if (!keyed_now)
            begin
                r.data  = b;
                r.keyed = 1'b0;
            end
            else
            begin
                gen_i = gen_i + 8'd1;
                gen_j = gen_j + perm[gen_i];
                t = perm[gen_i];
                perm[gen_i] = perm[gen_j];
                perm[gen_j] = t;
                r.data  = b ^ perm[byte_t'(perm[gen_i] + perm[gen_j])];
                r.keyed = 1'b1;
            end
            expected_out.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cipher_out_t e;
        int          bad;
        bad = 0;
        if (!rst_n)
        begin
            key_len   = 0;
            gen_i     = '0;
            gen_j     = '0;
            keyed_now = 1'b0;
            expected_out.delete();
            pending <= 0;
        end
        else
        begin
            // check the result before taking a new request, so a fresh one cannot mask it
            if (m_tvalid && m_tready)
            begin
                if (expected_out.size() == 0)
                begin
                    $error("unexpected result: byte_out %02h keyed %0b", m_tdata, m_tuser);
                    bad++;
                end
                else
                begin
                    e = expected_out.pop_front();
                    if (m_tdata !== e.data)
                    begin
                        $error("byte_out: expected %02h, got %02h", e.data, m_tdata);
                        bad++;
                    end
                    if (m_tuser !== e.keyed)
                    begin
                        $error("keyed: expected %0b, got %0b", e.keyed, m_tuser);
                        bad++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                absorb_request(req_kind_t'(s_tuser), s_tdata, s_tlast);
            pending   <= expected_out.size();
            err_total <= err_total + bad;
        end
    end

endmodule

>>> bench/rc4_stream_cipher_core_tb.sv
`timescale 1ns / 100ps

module rc4_stream_cipher_core_tb;
    import rc4_pkg::*;

    localparam int KEY_MAX_BYTES = 256;
    localparam int TOTAL_ITEMS   = 450;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = '0;
    logic       s_tuser = 1'b0;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;

    int       err_count;
    int       pending;
    int       burst_left = 0;
    int       items_sent = 0;
    int       rx_hold = 0;
    bit [8:0] rx_tick = '0;

    rc4_stream_cipher_core #(
        .KEY_MAX_BYTES(KEY_MAX_BYTES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    rc4_checker #(
        .KEY_MAX_BYTES(KEY_MAX_BYTES)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .err_count (err_count),
        .pending   (pending)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // receiver: cycle through always ready, random ready, long stalls and alternation
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_tready = 1'b0;
            rx_hold--;
        end
        else
        begin
            rx_tick++;
            case (rx_tick[8:7])
                2'd0: m_tready = 1'b1;
                2'd1: m_tready = ($urandom_range(0, 9) < 7);
                2'd2:
                begin
                    m_tready = 1'b1;
                    if ($urandom_range(0, 15) == 0)
                        rx_hold = $urandom_range(1, 24);
                end
                default: m_tready = rx_tick[0];
            endcase
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic push_req(input req_kind_t kind, input byte_t b, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
                s_tvalid = 1'b0;
            repeat (gap)
            begin
                s_tdata = 8'($urandom);
                s_tuser = 1'($urandom);
                s_tlast = 1'($urandom);
                @(negedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                       : $urandom_range(1, 12);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = b;
        s_tlast  = last;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        burst_left--;
        items_sent++;
        @(negedge clk);
    endtask

    task automatic push_data(input int count);
        for (int k = 0; k < count; k++)
            push_req(REQ_DATA, byte_t'($urandom), 1'($urandom));
    endtask

    // mix_pct: chance in percent of a data request slipped between key bytes
    task automatic load_key(input int len, input int mix_pct);
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 99) < mix_pct)
                push_req(REQ_DATA, byte_t'($urandom), 1'($urandom));
            push_req(REQ_KEY, byte_t'($urandom), k == len - 1);
        end
    endtask

    initial
    begin
        int pick;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // unkeyed pass-through, tlast on a data request must be ignored
        push_req(REQ_DATA, 8'h00, 1'b0);
        push_req(REQ_DATA, 8'hFF, 1'b1);
        push_req(REQ_DATA, 8'hA5, 1'b0);
        // first key, with data slipped in while it loads
        push_req(REQ_KEY, 8'h00, 1'b0);
        push_req(REQ_DATA, 8'h5A, 1'b0);
        push_req(REQ_KEY, 8'hFF, 1'b0);
        push_req(REQ_KEY, 8'h80, 1'b1);
        push_req(REQ_DATA, 8'h00, 1'b0);
        push_req(REQ_DATA, 8'hFF, 1'b1);
        push_req(REQ_DATA, 8'h01, 1'b0);
        // single-byte keys at both extremes
        push_req(REQ_KEY, 8'hFF, 1'b1);
        push_req(REQ_DATA, 8'h7F, 1'b0);
        push_req(REQ_DATA, 8'h80, 1'b0);
        push_req(REQ_KEY, 8'h00, 1'b1);
        push_req(REQ_DATA, 8'hFF, 1'b0);
        push_req(REQ_DATA, 8'h00, 1'b0);
        // new key while keyed: old generator keeps running until tlast
        push_req(REQ_KEY, 8'h4B, 1'b0);
        push_req(REQ_DATA, 8'h33, 1'b0);
        push_req(REQ_KEY, 8'h65, 1'b0);
        push_req(REQ_DATA, 8'hCC, 1'b1);
        push_req(REQ_KEY, 8'h79, 1'b1);
        push_data(4);

        // full-length key running past the limit, tlast on a dropped byte
        load_key(KEY_MAX_BYTES + 4, 1);
        push_data(8);

        while (items_sent < TOTAL_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                load_key(($urandom_range(0, 15) == 0) ? $urandom_range(17, 64)
                                                      : $urandom_range(1, 16),
                         ($urandom_range(0, 2) == 0) ? 25 : 0);
                push_data($urandom_range(4, 40));
            end
            else if (pick < 80)
                push_req(REQ_KEY, byte_t'($urandom), 1'b0);
            else if (pick < 85)
                push_req(REQ_KEY, byte_t'($urandom), 1'b1);
            else
                push_data($urandom_range(1, 6));
        end
        s_tvalid = 1'b0;

        wait (pending == 0);
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #(10_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
